>>> design/stfa_pkg.sv
`timescale 1ns / 1ps
// stfa_pkg: field widths, operation codes, defaults and the in-row search helpers
// shared by the slot table allocator and its mark store. No dependencies.
package stfa_pkg;

    // defaults for the top-level parameters
    localparam int SLOTS_DEF       = 256;
    localparam int RECORD_BITS_DEF = 32;

    // fixed field widths of the item and result beats
    localparam int OP_W  = 2;
    localparam int IDX_W = 8;
    localparam int REC_W = 32;
    localparam int CNT_W = 9;

    // occupied marks are kept in rows of MARK_W bits
    localparam int MARK_W  = 16;
    localparam int MARK_CW = 4;

    // operation codes
    localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_W-1:0] OP_SET    = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;
    localparam logic [OP_W-1:0] OP_GET    = 2'd3;

    typedef logic [MARK_W-1:0] mark_row_t;

    typedef struct packed {
        logic               found;
        logic [MARK_CW-1:0] col;
    } row_hit_t;

    // lowest free column strictly above col (or anywhere when whole is set)
    function automatic row_hit_t free_above(input mark_row_t bits,
                                            input logic [MARK_CW-1:0] col,
                                            input logic whole);
        row_hit_t hit;
        hit = '0;
        for (int j = MARK_W - 1; j >= 0; j--)
        begin
            if (!bits[j] && (whole || (MARK_CW'(j) > col)))
            begin
                hit.found = 1'b1;
                hit.col   = MARK_CW'(j);
            end
        end
        return hit;
    endfunction

    // highest occupied column strictly below col (or anywhere when whole is set)
    function automatic row_hit_t set_below(input mark_row_t bits,
                                           input logic [MARK_CW-1:0] col,
                                           input logic whole);
        row_hit_t hit;
        hit = '0;
        for (int j = 0; j < MARK_W; j++)
        begin
            if (bits[j] && (whole || (MARK_CW'(j) < col)))
            begin
                hit.found = 1'b1;
                hit.col   = MARK_CW'(j);
            end
        end
        return hit;
    endfunction

endpackage

>>> design/slot_table_first_free_allocator.sv
`timescale 1ns / 1ps
// slot_table_first_free_allocator: slot table with first-free allocation, occupied
// count and used extent. Depends on stfa_pkg and stfa_mark_mem.
//
//  channel   signals                                          direction
//  item      item_valid, item_ready, operation, slot_index,   in
//            record
//  result    result_valid, result_ready, status,              out
//            placed_index, read_record, slot_filled,
//            occupied_total, extent
//
// The accept cycle issues the mark-row read and, for a get, the record read; the next
// cycle modifies and writes back. Add, and set of the lowest free slot, then scan one
// mark row per cycle upward for the next free slot; remove of the last occupied slot
// scans one row per cycle downward.
// Reset clears all marks and counters at once. A full result register stalls the
// sequencer; the next item is taken in the cycle the current result is loaded into it.
module slot_table_first_free_allocator #(
    parameter int SLOTS       = stfa_pkg::SLOTS_DEF,
    parameter int RECORD_BITS = stfa_pkg::RECORD_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_ready,
    input  logic [stfa_pkg::OP_W-1:0]     operation,
    input  logic [stfa_pkg::IDX_W-1:0]    slot_index,
    input  logic [stfa_pkg::REC_W-1:0]    record,
    output logic                          result_valid,
    input  logic                          result_ready,
    output logic                          status,
    output logic [stfa_pkg::IDX_W-1:0]    placed_index,
    output logic [stfa_pkg::REC_W-1:0]    read_record,
    output logic                          slot_filled,
    output logic [stfa_pkg::CNT_W-1:0]    occupied_total,
    output logic [stfa_pkg::CNT_W-1:0]    extent
);
    import stfa_pkg::*;

    localparam int ROWS = (SLOTS + MARK_W - 1) / MARK_W;
    localparam int RAW  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int BAW  = RAW + MARK_CW;
    localparam int IW   = $clog2(SLOTS);
    localparam int CW   = $clog2(SLOTS + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOOK = 3'd1;
    localparam logic [2:0] S_UP   = 3'd2;
    localparam logic [2:0] S_DOWN = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    // sequencer and table state
    logic [2:0]             state_reg, state_next;
    logic [OP_W-1:0]        op_reg, op_next;
    logic [BAW-1:0]         pos_reg, pos_next;
    logic [RECORD_BITS-1:0] rec_reg, rec_next;
    logic [RAW-1:0]         row_reg, row_next;
    logic [CW-1:0]          lf_reg, lf_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic [CW-1:0]          ext_reg, ext_next;

    // pending result fields
    logic                   r_status_reg, r_status_next;
    logic [IDX_W-1:0]       r_placed_reg, r_placed_next;
    logic                   r_filled_reg, r_filled_next;
    logic [REC_W-1:0]       r_read_reg, r_read_next;

    // result register
    logic                   result_valid_reg;
    logic                   status_reg;
    logic [IDX_W-1:0]       placed_reg;
    logic [REC_W-1:0]       read_reg;
    logic                   filled_reg;
    logic [CNT_W-1:0]       total_reg;
    logic [CNT_W-1:0]       out_ext_reg;

    // memory ports
    logic                   mk_rd_en, mk_wr_en;
    logic [RAW-1:0]         mk_rd_addr, mk_wr_addr;
    mark_row_t              mk_rd_data, mk_wr_data;
    logic [RECORD_BITS-1:0] rec_mem [SLOTS];
    logic [RECORD_BITS-1:0] rec_rd_reg;
    logic                   rec_rd_en, rec_wr_en;
    logic [IW-1:0]          rec_rd_addr, rec_wr_addr;

    // working signals
    logic                   acc, out_free, out_load, go;
    logic [BAW-1:0]         acc_pos;
    logic [RAW-1:0]         pos_row, cur_row;
    logic [MARK_CW-1:0]     pos_col;
    mark_row_t              pos_bit;
    logic                   cur_mark, whole, need_up, need_dn;
    row_hit_t               up_hit, dn_hit;
    logic [BAW-1:0]         up_slot, dn_slot;

    stfa_mark_mem #(
        .ROWS (ROWS)
    ) u_marks (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (mk_rd_en),
        .rd_addr (mk_rd_addr),
        .rd_data (mk_rd_data),
        .wr_en   (mk_wr_en),
        .wr_addr (mk_wr_addr),
        .wr_data (mk_wr_data)
    );

    // handshakes
    assign out_free   = !result_valid_reg || result_ready;
    assign out_load   = (state_reg == S_EMIT) && out_free;
    assign item_ready = (state_reg == S_IDLE) || out_load;
    assign acc        = item_valid && item_ready;

    // row search over the row just read
    assign pos_row  = pos_reg[BAW-1:MARK_CW];
    assign pos_col  = pos_reg[MARK_CW-1:0];
    assign pos_bit  = mark_row_t'(1) << pos_col;
    assign cur_mark = mk_rd_data[pos_col];
    assign whole    = (state_reg != S_LOOK);
    assign cur_row  = (state_reg == S_LOOK) ? pos_row : row_reg;
    assign up_hit   = free_above(mk_rd_data, pos_col, whole);
    assign dn_hit   = set_below(mk_rd_data, pos_col, whole);
    assign up_slot  = {cur_row, up_hit.col};
    assign dn_slot  = {cur_row, dn_hit.col};

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        pos_next      = pos_reg;
        rec_next      = rec_reg;
        row_next      = row_reg;
        lf_next       = lf_reg;
        cnt_next      = cnt_reg;
        ext_next      = ext_reg;
        r_status_next = r_status_reg;
        r_placed_next = r_placed_reg;
        r_filled_next = r_filled_reg;
        r_read_next   = r_read_reg;
        mk_rd_en      = 1'b0;
        mk_rd_addr    = row_reg;
        mk_wr_en      = 1'b0;
        mk_wr_addr    = pos_row;
        mk_wr_data    = mk_rd_data;
        rec_wr_en     = 1'b0;
        rec_rd_en     = 1'b0;
        go            = 1'b0;
        acc_pos       = '0;
        need_up       = 1'b0;
        need_dn       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
            end
            S_LOOK:
            begin
                state_next = S_EMIT;
                unique case (op_reg)
                    OP_ADD:
                    begin
                        mk_wr_en      = 1'b1;
                        mk_wr_data    = mk_rd_data | pos_bit;
                        rec_wr_en     = 1'b1;
                        cnt_next      = cnt_reg + CW'(1);
                        if (CW'(pos_reg) >= ext_reg)
                        begin
                            ext_next = CW'(pos_reg) + CW'(1);
                        end
                        r_placed_next = IDX_W'(pos_reg);
                        need_up       = 1'b1;
                    end
                    OP_SET:
                    begin
                        rec_wr_en     = 1'b1;
                        r_filled_next = cur_mark;
                        if (!cur_mark)
                        begin
                            mk_wr_en   = 1'b1;
                            mk_wr_data = mk_rd_data | pos_bit;
                            cnt_next   = cnt_reg + CW'(1);
                            if (CW'(pos_reg) >= ext_reg)
                            begin
                                ext_next = CW'(pos_reg) + CW'(1);
                            end
                            need_up    = (lf_reg == CW'(pos_reg));
                        end
                    end
                    OP_REMOVE:
                    begin
                        if (cur_mark)
                        begin
                            r_filled_next = 1'b1;
                            mk_wr_en      = 1'b1;
                            mk_wr_data    = mk_rd_data & ~pos_bit;
                            cnt_next      = cnt_reg - CW'(1);
                            if (CW'(pos_reg) < lf_reg)
                            begin
                                lf_next = CW'(pos_reg);
                            end
                            need_dn       = ((CW'(pos_reg) + CW'(1)) == ext_reg);
                        end
                    end
                    OP_GET:
                    begin
                        r_filled_next = cur_mark;
                        r_read_next   = cur_mark ? REC_W'(rec_rd_reg) : '0;
                    end
                endcase
            end
            S_UP:
            begin
                need_up = 1'b1;
            end
            S_DOWN:
            begin
                need_dn = 1'b1;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // upward scan for the next free slot, one row per cycle
        if (need_up)
        begin
            if (up_hit.found)
            begin
                lf_next    = (int'(up_slot) < SLOTS) ? CW'(up_slot) : CW'(SLOTS);
                state_next = S_EMIT;
            end
            else if (cur_row == RAW'(ROWS - 1))
            begin
                lf_next    = CW'(SLOTS);
                state_next = S_EMIT;
            end
            else
            begin
                mk_rd_en   = 1'b1;
                mk_rd_addr = cur_row + RAW'(1);
                row_next   = cur_row + RAW'(1);
                state_next = S_UP;
            end
        end

        // downward scan for the highest occupied slot, one row per cycle
        if (need_dn)
        begin
            if (dn_hit.found)
            begin
                ext_next   = CW'(dn_slot) + CW'(1);
                state_next = S_EMIT;
            end
            else if (cur_row == '0)
            begin
                ext_next   = '0;
                state_next = S_EMIT;
            end
            else
            begin
                mk_rd_en   = 1'b1;
                mk_rd_addr = cur_row - RAW'(1);
                row_next   = cur_row - RAW'(1);
                state_next = S_DOWN;
            end
        end

        // accept a new item beat and issue its reads
        if (acc)
        begin
            op_next       = operation;
            rec_next      = RECORD_BITS'(record);
            r_status_next = 1'b0;
            r_placed_next = slot_index;
            r_filled_next = 1'b0;
            r_read_next   = '0;
            if (operation == OP_ADD)
            begin
                go      = (int'(lf_reg) < SLOTS);
                acc_pos = BAW'(lf_reg);
                if (!go)
                begin
                    r_status_next = 1'b1;
                    r_placed_next = '0;
                end
            end
            else
            begin
                go      = (int'(slot_index) < SLOTS);
                acc_pos = BAW'(slot_index);
            end
            pos_next   = acc_pos;
            mk_rd_en   = go;
            mk_rd_addr = acc_pos[BAW-1:MARK_CW];
            rec_rd_en  = go && (operation == OP_GET);
            state_next = go ? S_LOOK : S_EMIT;
        end
    end

    assign rec_rd_addr = IW'(acc_pos);
    assign rec_wr_addr = IW'(pos_reg);

    // record memory
    always_ff @(posedge clk)
    begin
        if (rec_wr_en)
        begin
            rec_mem[rec_wr_addr] <= rec_reg;
        end
        if (rec_rd_en)
        begin
            rec_rd_reg <= rec_mem[rec_rd_addr];
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            lf_reg           <= '0;
            cnt_reg          <= '0;
            ext_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            lf_reg    <= lf_next;
            cnt_reg   <= cnt_next;
            ext_reg   <= ext_next;
            if (out_load)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        pos_reg      <= pos_next;
        rec_reg      <= rec_next;
        row_reg      <= row_next;
        r_status_reg <= r_status_next;
        r_placed_reg <= r_placed_next;
        r_filled_reg <= r_filled_next;
        r_read_reg   <= r_read_next;
        if (out_load)
        begin
            status_reg  <= r_status_reg;
            placed_reg  <= r_placed_reg;
            read_reg    <= r_read_reg;
            filled_reg  <= r_filled_reg;
            total_reg   <= CNT_W'(cnt_reg);
            out_ext_reg <= CNT_W'(ext_reg);
        end
    end

    assign result_valid   = result_valid_reg;
    assign status         = status_reg;
    assign placed_index   = placed_reg;
    assign read_record    = read_reg;
    assign slot_filled    = filled_reg;
    assign occupied_total = total_reg;
    assign extent         = out_ext_reg;

endmodule

>>> design/stfa_mark_mem.sv
`timescale 1ns / 1ps
// stfa_mark_mem: row memory of occupied marks with registered read.
// Per-row valid flops make unwritten rows read as all free. Uses stfa_pkg.
module stfa_mark_mem #(
    parameter int ROWS = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     rd_en,
    input  logic [((ROWS > 1) ? $clog2(ROWS) : 1)-1:0] rd_addr,
    output stfa_pkg::mark_row_t      rd_data,
    input  logic                     wr_en,
    input  logic [((ROWS > 1) ? $clog2(ROWS) : 1)-1:0] wr_addr,
    input  stfa_pkg::mark_row_t      wr_data
);
    import stfa_pkg::*;

    mark_row_t        mem [ROWS];
    logic [ROWS-1:0]  row_vld_reg;
    mark_row_t        rd_raw_reg;
    logic             rd_vld_reg;

    // storage array and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_raw_reg <= mem[rd_addr];
        end
    end

    // row valid bits: cleared at reset, set on first write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_vld_reg <= '0;
            rd_vld_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                row_vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= row_vld_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_vld_reg ? rd_raw_reg : '0;

endmodule
